// ===== design/sat_pkg.sv =====
// Shared constants, types and codes for the shell argument tokenizer.
package sat_pkg;

    localparam int BUFFER_SIZE = 256;
    localparam int MAX_ARGS    = 16;

    localparam int POS_W = $clog2(BUFFER_SIZE + 1);
    localparam int ARG_W = $clog2(MAX_ARGS + 1);

    // Parser state codes
    localparam logic [1:0] PM_SEARCH = 2'd0;
    localparam logic [1:0] PM_QUOTED = 2'd1;
    localparam logic [1:0] PM_PLAIN  = 2'd2;

    // Input modes
    localparam logic MODE_CHAR    = 1'b0;
    localparam logic MODE_NEWLINE = 1'b1;

    // Characters of interest
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [POS_W-1:0] POS_LIMIT  = POS_W'(BUFFER_SIZE);
    localparam logic [POS_W-1:0] POS_LIMIT1 = POS_W'(BUFFER_SIZE - 1);
    localparam logic [ARG_W-1:0] ARG_LIMIT  = ARG_W'(MAX_ARGS);

    typedef struct packed {
        logic [1:0]       pmode;
        logic             esc;
        logic [POS_W-1:0] pos;
        logic [ARG_W-1:0] args;
        logic             ovf;
    } sat_state_t;

    typedef struct packed {
        logic [1:0] write_count;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] write_position;
        logic [4:0] arg_count;
        logic [1:0] parse_state;
        logic       escape_pending;
        logic       overflow;
    } sat_result_t;

endpackage

// ===== design/sat_ifs.sv =====
// Valid/ready channel interfaces for tokenizer input and results.
interface sat_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] char_in;

    modport source (output valid, output mode, output char_in, input ready);
    modport sink   (input valid, input mode, input char_in, output ready);
endinterface

interface sat_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] write_count;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] write_position;
    logic [4:0] arg_count;
    logic [1:0] parse_state;
    logic       escape_pending;
    logic       overflow;

    modport source (output valid, output write_count, output first_byte,
                    output second_byte, output write_position, output arg_count,
                    output parse_state, output escape_pending, output overflow,
                    input ready);
    modport sink   (input valid, input write_count, input first_byte,
                    input second_byte, input write_position, input arg_count,
                    input parse_state, input escape_pending, input overflow,
                    output ready);
endinterface

// ===== design/sat_step.sv =====
// Next-state and result logic for one tokenizer character.
module sat_step (
    input  sat_pkg::sat_state_t  cur,
    input  logic                 mode,
    input  logic [7:0]           char_in,
    output sat_pkg::sat_state_t  nxt,
    output sat_pkg::sat_result_t res
);
    import sat_pkg::*;

    logic [1:0]       pmode;
    logic             esc;
    logic             start;
    logic [1:0]       produced;
    logic [7:0]       byte0;
    logic [7:0]       byte1;
    logic             fit0;
    logic             fit1;
    logic [1:0]       accepted;
    logic             arg_sat;
    logic [ARG_W-1:0] args_n;
    logic [POS_W+7:0] pos_ext;
    logic [ARG_W+4:0] args_ext;
    logic             in_arg;

    always_comb
    begin
        pmode    = cur.pmode;
        esc      = cur.esc;
        start    = 1'b0;
        produced = 2'd0;
        byte0    = CH_NUL;
        byte1    = CH_NUL;
        in_arg   = (cur.pmode == PM_QUOTED) || (cur.pmode == PM_PLAIN);

        if (in_arg)
        begin
            if (cur.esc)
            begin
                esc = 1'b0;
                if (char_in == CH_X)
                begin
                    byte0    = CH_BSLASH;
                    byte1    = char_in;
                    produced = 2'd2;
                end
                else
                begin
                    byte0    = char_in;
                    produced = 2'd1;
                end
            end
            else if (char_in == CH_QUOTE)
                pmode = (cur.pmode == PM_QUOTED) ? PM_PLAIN : PM_QUOTED;
            else if (char_in == CH_BSLASH)
                esc = 1'b1;
            else if (char_in == CH_SPACE && cur.pmode == PM_PLAIN)
            begin
                byte0    = CH_NUL;
                produced = 2'd1;
                pmode    = PM_SEARCH;
            end
            else
            begin
                byte0    = char_in;
                produced = 2'd1;
            end
        end
        else
        begin
            // searching; an unused state code behaves the same
            if (char_in == CH_SPACE)
                pmode = PM_SEARCH;
            else if (char_in == CH_QUOTE)
            begin
                start = 1'b1;
                pmode = PM_QUOTED;
            end
            else if (char_in == CH_BSLASH)
            begin
                start = 1'b1;
                esc   = 1'b1;
                pmode = PM_PLAIN;
            end
            else
            begin
                start    = 1'b1;
                byte0    = char_in;
                produced = 2'd1;
                pmode    = PM_PLAIN;
            end
        end

        // argument count, saturating
        arg_sat = start && (cur.args >= ARG_LIMIT);
        args_n  = (start && !arg_sat) ? cur.args + ARG_W'(1) : cur.args;

        // buffer space: only a prefix of the produced bytes is stored
        fit0 = cur.pos < POS_LIMIT;
        fit1 = cur.pos < POS_LIMIT1;
        case (produced)
            2'd1:    accepted = fit0 ? 2'd1 : 2'd0;
            2'd2:    accepted = fit1 ? 2'd2 : (fit0 ? 2'd1 : 2'd0);
            default: accepted = 2'd0;
        endcase

        if (mode == MODE_NEWLINE)
        begin
            nxt.pmode = PM_SEARCH;
            nxt.esc   = 1'b0;
            nxt.pos   = '0;
            nxt.args  = '0;
            nxt.ovf   = 1'b0;
            accepted  = 2'd0;
        end
        else
        begin
            nxt.pmode = pmode;
            nxt.esc   = esc;
            nxt.pos   = cur.pos + POS_W'(accepted);
            nxt.args  = args_n;
            nxt.ovf   = cur.ovf || arg_sat || (accepted != produced);
        end

        pos_ext  = {8'd0, cur.pos};
        args_ext = {5'd0, nxt.args};

        res.write_count    = accepted;
        res.first_byte     = (accepted != 2'd0) ? byte0 : CH_NUL;
        res.second_byte    = (accepted == 2'd2) ? byte1 : CH_NUL;
        res.write_position = (mode == MODE_NEWLINE) ? 8'd0 : pos_ext[7:0];
        res.arg_count      = args_ext[4:0];
        res.parse_state    = (nxt.pmode == PM_QUOTED) ? PM_QUOTED
                           : ((nxt.pmode == PM_PLAIN) ? PM_PLAIN : PM_SEARCH);
        res.escape_pending = nxt.esc;
        res.overflow       = nxt.ovf;
    end

endmodule

// ===== design/shell_argument_tokenizer_top.sv =====
// Top level of the shell argument tokenizer: parser state and result register.
//
//  channel  | dir | payload                                      | transfer when
//  ---------+-----+----------------------------------------------+----------------
//  in_ch    | in  | mode, char_in                                | valid && ready
//  out_ch   | out | write_count, first_byte, second_byte,        | valid && ready
//           |     | write_position, arg_count, parse_state,      |
//           |     | escape_pending, overflow                     |
//
// One character per cycle while out_ch drains: the parser state updates in the cycle of the input
// transfer, and the result appears in the output register on the next cycle.
// rst_n clears the parser to searching with empty buffer, zero count and no
// overflow, and empties the output register.
// in_ch.ready is high when the output register is empty or is being read in
// the same cycle; a stall on out_ch holds the result and back-pressures in_ch.
module shell_argument_tokenizer_top (
    input  logic clk,
    input  logic rst_n,
    sat_in_if.sink    in_ch,
    sat_out_if.source out_ch
);
    import sat_pkg::*;

    sat_state_t  state_reg;
    sat_state_t  state_next;
    sat_result_t step_res;
    sat_result_t res_reg;
    logic        out_valid_reg;
    logic        in_xfer;

    sat_step u_step (
        .cur     (state_reg),
        .mode    (in_ch.mode),
        .char_in (in_ch.char_in),
        .nxt     (state_next),
        .res     (step_res)
    );

    // output register frees up when its result is taken
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_xfer     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.pmode <= PM_SEARCH;
            state_reg.esc   <= 1'b0;
            state_reg.pos   <= '0;
            state_reg.args  <= '0;
            state_reg.ovf   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_xfer)
                state_reg <= state_next;
            if (in_xfer)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            res_reg <= step_res;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.write_count    = res_reg.write_count;
    assign out_ch.first_byte     = res_reg.first_byte;
    assign out_ch.second_byte    = res_reg.second_byte;
    assign out_ch.write_position = res_reg.write_position;
    assign out_ch.arg_count      = res_reg.arg_count;
    assign out_ch.parse_state    = res_reg.parse_state;
    assign out_ch.escape_pending = res_reg.escape_pending;
    assign out_ch.overflow       = res_reg.overflow;

endmodule

// ===== verif/sat_result_checker.sv =====
// Result checker for the shell argument tokenizer: predicts each result and compares it.
`timescale 1ns / 1ps

module sat_result_checker (
    input  logic      clk,
    input  logic      rst_n,
    sat_in_if         in_ch,
    sat_out_if        out_ch,
    output int        mismatches,
    output int        outstanding,
    output int        results_seen,
    output int        overflow_results
);
    import sat_pkg::*;

    // predictor copy of the parser state
    logic [1:0]  tok_mode;
    logic        tok_esc;
    int unsigned tok_pos;
    int unsigned tok_args;
    logic        tok_ovf;

    sat_result_t expected_results[$];
    int          error_total;
    int          result_total;
    int          overflow_total;
    int          pending_total;

    assign mismatches       = error_total;
    assign outstanding      = pending_total;
    assign results_seen     = result_total;
    assign overflow_results = overflow_total;

    function automatic void count_arg();
        if (tok_args < MAX_ARGS)
            tok_args++;
        else
            tok_ovf = 1'b1;
    endfunction

    function automatic sat_result_t tokenize_char(input logic m, input logic [7:0] c);
        logic [7:0]  emit [2];
        int unsigned n;
        int unsigned kept;
        int unsigned start;
        sat_result_t r;
        emit[0] = CH_NUL;
        emit[1] = CH_NUL;
        n       = 0;
        kept    = 0;
        if (m == MODE_NEWLINE)
        begin
            tok_mode = PM_SEARCH;
            tok_esc  = 1'b0;
            tok_pos  = 0;
            tok_args = 0;
            tok_ovf  = 1'b0;
        end
        else if (tok_mode == PM_QUOTED || tok_mode == PM_PLAIN)
        begin
            if (tok_esc)
            begin
                // escaped x keeps its backslash
                if (c == CH_X)
                begin
                    emit[n] = CH_BSLASH;
                    n++;
                end
                emit[n] = c;
                n++;
                tok_esc = 1'b0;
            end
            else if (c == CH_QUOTE)
                tok_mode = (tok_mode == PM_QUOTED) ? PM_PLAIN : PM_QUOTED;
            else if (c == CH_BSLASH)
                tok_esc = 1'b1;
            else if (c == CH_SPACE && tok_mode == PM_PLAIN)
            begin
                emit[n] = CH_NUL;
                n++;
                tok_mode = PM_SEARCH;
            end
            else
            begin
                emit[n] = c;
                n++;
            end
        end
        else
        begin
            // searching; an unknown state code behaves the same
            if (c == CH_QUOTE)
            begin
                count_arg();
                tok_mode = PM_QUOTED;
            end
            else if (c == CH_BSLASH)
            begin
                tok_esc = 1'b1;
                count_arg();
                tok_mode = PM_PLAIN;
            end
            else if (c != CH_SPACE)
            begin
                emit[n] = c;
                n++;
                count_arg();
                tok_mode = PM_PLAIN;
            end
        end
        start = tok_pos;
        for (int i = 0; i < n; i++)
        begin
            if (tok_pos < BUFFER_SIZE)
            begin
                tok_pos++;
                kept++;
            end
            else
                tok_ovf = 1'b1;
        end
        r.write_count    = 2'(kept);
        r.first_byte     = (kept >= 1) ? emit[0] : CH_NUL;
        r.second_byte    = (kept >= 2) ? emit[1] : CH_NUL;
        r.write_position = 8'(start);
        r.arg_count      = 5'(tok_args);
        r.parse_state    = tok_mode;
        r.escape_pending = tok_esc;
        r.overflow       = tok_ovf;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sat_result_t want;
        if (!rst_n)
        begin
            tok_mode       = PM_SEARCH;
            tok_esc        = 1'b0;
            tok_pos        = 0;
            tok_args       = 0;
            tok_ovf        = 1'b0;
            error_total    = 0;
            result_total   = 0;
            overflow_total = 0;
            pending_total  = 0;
            expected_results.delete();
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                result_total++;
                if (out_ch.overflow)
                    overflow_total++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result transfer with no expected result pending", $time);
                    error_total++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("write_count", want.write_count, out_ch.write_count);
                    check_field("first_byte", want.first_byte, out_ch.first_byte);
                    check_field("second_byte", want.second_byte, out_ch.second_byte);
                    check_field("write_position", want.write_position,
                                out_ch.write_position);
                    check_field("arg_count", want.arg_count, out_ch.arg_count);
                    check_field("parse_state", want.parse_state, out_ch.parse_state);
                    check_field("escape_pending", want.escape_pending,
                                out_ch.escape_pending);
                    check_field("overflow", want.overflow, out_ch.overflow);
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_results.push_back(tokenize_char(in_ch.mode, in_ch.char_in));
            pending_total = expected_results.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the tokenizer testbench: clock, reset, character stimulus, result sink, verdict.
`timescale 1ns / 1ps

module testbench;
    import sat_pkg::*;

    // Sender runs until this many transfers have gone in, finishing the line in progress.
    localparam int TARGET_ITEMS = 600;
    // Length of the one long receiver hold that backs up the input channel.
    localparam int HOLD_CYCLES  = 150;

    logic clk;
    logic rst_n;

    sat_in_if  in_ch ();
    sat_out_if out_ch ();

    int mismatches;
    int outstanding;
    int results_seen;
    int overflow_results;

    int items_sent;
    int lines_sent;
    bit quiet;          // when set neither side inserts gaps
    bit hold_request;   // asks the sink process for one long stall

    shell_argument_tokenizer_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    sat_result_checker tok_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_ch            (in_ch),
        .out_ch           (out_ch),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .results_seen     (results_seen),
        .overflow_results (overflow_results)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Gap length for either side: mostly none, often short, now and then long.
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // One transfer on in_ch. Called at a rising edge; returns at the edge where the
    // transfer happened. valid only drops when a gap is taken, so it is never
    // lowered and raised in the same time step.
    task automatic send_item(input logic m, input logic [7:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.mode    <= m;
        in_ch.char_in <= c;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_char(input logic [7:0] c);
        send_item(MODE_CHAR, c);
    endtask

    // Any byte, with the separators and escape characters heavily weighted.
    function automatic logic [7:0] noise_char();
        int r;
        r = $urandom_range(0, 19);
        if (r < 5)
            return CH_SPACE;
        else if (r < 7)
            return CH_QUOTE;
        else if (r < 9)
            return CH_BSLASH;
        else if (r < 11)
            return CH_X;
        else if (r == 11)
            return CH_NUL;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // Ordinary argument byte: never a separator, quote or backslash.
    function automatic logic [7:0] word_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == CH_SPACE || c == CH_QUOTE || c == CH_BSLASH)
            c = CH_X;
        return c;
    endfunction

    // Word body: plain bytes with the odd escape; spaces allowed inside quotes.
    task automatic send_word(input int len, input bit quoted);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_char(CH_BSLASH);
                send_char(($urandom_range(0, 2) == 0) ? CH_X : noise_char());
            end
            else if (quoted && $urandom_range(0, 4) == 0)
                send_char(CH_SPACE);
            else
                send_char(word_char());
        end
    endtask

    // One argument in plain, quoted or mixed form, then separating spaces.
    task automatic send_token();
        int form;
        form = $urandom_range(0, 2);
        if (form != 1)
            send_word($urandom_range(1, 8), 1'b0);
        if (form != 0)
        begin
            send_char(CH_QUOTE);
            send_word($urandom_range(0, 10), 1'b1);
            send_char(CH_QUOTE);
        end
        repeat ($urandom_range(0, 3)) send_char(CH_SPACE);
    endtask

    // A new line followed by one kind of content:
    //   0 noise, 1 long enough to run off the end of the buffer,
    //   2 more arguments than the counter holds, else a normal command line.
    task automatic send_line(input int kind);
        send_item(MODE_NEWLINE, 8'($urandom_range(0, 255)));
        lines_sent++;
        case (kind)
            0:
                repeat ($urandom_range(1, 40)) send_char(noise_char());
            1:
            begin
                for (int n = 0; n < $urandom_range(270, 300); n += 9)
                begin
                    send_word(8, 1'b0);
                    send_char(CH_SPACE);
                end
            end
            2:
            begin
                repeat ($urandom_range(17, 24))
                begin
                    send_char(word_char());
                    send_char(CH_SPACE);
                end
            end
            default:
                repeat ($urandom_range(1, 6)) send_token();
        endcase
    endtask

    // Receiver: random stalls, plus one long hold on request. Each pass makes one
    // assignment to ready and then waits at least one edge.
    initial
    begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge clk);
        wait (rst_n);
        forever
        begin
            gap = pick_gap();
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        in_ch.valid   = 1'b0;
        in_ch.mode    = MODE_CHAR;
        in_ch.char_in = CH_NUL;
        items_sent    = 0;
        lines_sent    = 0;
        quiet         = 1'b0;
        hold_request  = 1'b0;
        rst_n         = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every parser transition, escapes in both argument states,
        // escaped x, a literal zero byte, the byte extremes and a new line
        // arriving in the middle of an argument.
        send_item(MODE_NEWLINE, 8'hA5);
        send_char(CH_SPACE);        // space while searching
        send_char(8'h61);           // starts a plain argument
        send_char(8'hFF);
        send_char(CH_QUOTE);        // plain -> quoted
        send_char(CH_SPACE);        // stored inside quotes
        send_char(CH_BSLASH);
        send_char(CH_X);            // escaped x writes two bytes
        send_char(CH_QUOTE);        // quoted -> plain
        send_char(CH_SPACE);        // terminator byte
        send_char(CH_BSLASH);       // escape opens an argument
        send_char(CH_QUOTE);        // literal quote
        send_char(CH_BSLASH);
        send_char(CH_SPACE);        // literal space
        send_char(CH_NUL);          // zero byte as content
        send_char(CH_SPACE);
        send_char(CH_QUOTE);        // quote opens an argument
        send_char(CH_BSLASH);
        send_char(CH_BSLASH);       // literal backslash
        send_char(CH_QUOTE);
        send_char(CH_X);            // unescaped x is ordinary
        send_item(MODE_NEWLINE, CH_NUL);
        send_char(CH_X);
        send_item(MODE_NEWLINE, 8'hFF);

        // Random lines. The first long line runs under the long receiver hold,
        // so the result register fills and the input channel stalls.
        hold_request = 1'b1;
        send_line(1);
        send_line(2);
        while (items_sent < TARGET_ITEMS)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 11))
                0, 1:    send_line(0);
                2:       send_line(1);
                3:       send_line(2);
                default: send_line(3);
            endcase
        end
        quiet = 1'b0;
        in_ch.valid <= 1'b0;

        // Drain: one edge so the last transfer is booked, then all results in.
        @(posedge clk);
        wait (outstanding == 0);
        repeat (4) @(posedge clk);

        $display("Sent %0d characters and line starts over %0d command lines.",
                 items_sent, lines_sent);
        $display("Checked %0d results, %0d of them with overflow flagged.",
                 results_seen, overflow_results);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
